// File: src/cspf_pkg.sv
package cspf_pkg;

    localparam int POS_W       = 12;
    localparam int LEVEL_W     = 8;
    localparam int CMD_W       = 3;
    localparam int VAL_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_DELAY_W = 16;

    localparam int STEP_SIZE_DEF   = 1;
    localparam int DELAY_WIDTH_DEF = 16;

    localparam logic [POS_W-1:0]       POS_MAX          = '1;
    localparam logic [LEVEL_W-1:0]     FULL_LEVEL       = '1;
    localparam logic [POS_W-1:0]       OPEN_POS_RST     = 12'd0;
    localparam logic [POS_W-1:0]       CLOSED_POS_RST   = 12'd180;
    localparam logic [CFG_DELAY_W-1:0] SERVO_DELAY_RST  = 16'd10;
    localparam logic [CFG_DELAY_W-1:0] FADE_DELAY_RST   = 16'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_STARTUP = 3'd1,
        CMD_SHUTTER = 3'd2,
        CMD_HALT    = 3'd3,
        CMD_LIGHT   = 3'd4,
        CMD_BRIGHT  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLOSED = 2'd0,
        ST_OPEN   = 2'd1,
        ST_MOVING = 2'd2,
        ST_HALTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIR_NONE    = 2'd0,
        DIR_OPENING = 2'd1,
        DIR_CLOSING = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_POS      = 3'd0,
        CFG_CLOSED_POS    = 3'd1,
        CFG_SERVO_DELAY   = 3'd2,
        CFG_FADE_DELAY    = 3'd3,
        CFG_START_OPEN    = 3'd4,
        CFG_PANEL_AT_START = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]       open_pos;
        logic [POS_W-1:0]       closed_pos;
        logic [CFG_DELAY_W-1:0] servo_delay;
        logic [CFG_DELAY_W-1:0] fade_delay;
        logic                   start_open;
        logic                   panel_on_at_start;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   cur_pos;
        logic [POS_W-1:0]   tgt_pos;
        status_t            status;
        dir_t               dir;
        logic               light;
        logic [LEVEL_W-1:0] chosen_level;
        logic [LEVEL_W-1:0] tgt_level;
        logic [LEVEL_W-1:0] cur_level;
    } state_t;

    typedef struct packed {
        logic swrite;
        logic pwrite;
        logic save;
    } flags_t;

endpackage

// File: src/cspf_step.sv
module cspf_step
    import cspf_pkg::*;
#(
    parameter int STEP_SIZE   = STEP_SIZE_DEF,
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
)
(
    input  state_t                 st,
    input  cfg_t                   cfg,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [VAL_W-1:0]       val,
    input  logic [DELAY_WIDTH-1:0] fade_ticks,
    input  logic [DELAY_WIDTH-1:0] move_ticks,
    output state_t                 st_next,
    output logic [DELAY_WIDTH-1:0] fade_next,
    output logic [DELAY_WIDTH-1:0] move_next,
    output flags_t                 flags
);

    localparam int CMP_W = (DELAY_WIDTH > CFG_DELAY_W) ? DELAY_WIDTH : CFG_DELAY_W;
    localparam logic [DELAY_WIDTH-1:0] TICK_MAX = '1;
    localparam logic [POS_W:0]         STEP_EXT = (POS_W+1)'(STEP_SIZE);

    logic [DELAY_WIDTH-1:0] fade_inc;
    logic [DELAY_WIDTH-1:0] move_inc;
    logic                   fade_due;
    logic                   move_due;
    logic [POS_W:0]         pos_sum;
    logic [POS_W-1:0]       pos_dec;
    logic [POS_W-1:0]       pos_inc;

    // saturating elapsed-tick counters
    assign fade_inc = (fade_ticks == TICK_MAX) ? fade_ticks : fade_ticks + DELAY_WIDTH'(1);
    assign move_inc = (move_ticks == TICK_MAX) ? move_ticks : move_ticks + DELAY_WIDTH'(1);
    assign fade_due = CMP_W'(fade_inc) >= CMP_W'(cfg.fade_delay);
    assign move_due = CMP_W'(move_inc) >= CMP_W'(cfg.servo_delay);

    assign pos_sum = {1'b0, st.cur_pos} + STEP_EXT;
    assign pos_inc = (pos_sum > {1'b0, POS_MAX}) ? POS_MAX : pos_sum[POS_W-1:0];
    assign pos_dec = ({1'b0, st.cur_pos} >= STEP_EXT) ?
                     (st.cur_pos - STEP_EXT[POS_W-1:0]) : '0;

    always_comb
    begin
        st_next   = st;
        fade_next = fade_ticks;
        move_next = move_ticks;
        flags     = '0;
        case (cmd)
            CMD_TICK:
            begin
                fade_next = fade_inc;
                move_next = move_inc;
                if (fade_due)
                begin
                    if (st.cur_level < st.tgt_level)
                    begin
                        st_next.cur_level = st.cur_level + LEVEL_W'(1);
                        flags.pwrite = 1'b1;
                    end
                    else if (st.cur_level > st.tgt_level)
                    begin
                        st_next.cur_level = st.cur_level - LEVEL_W'(1);
                        flags.pwrite = 1'b1;
                    end
                    fade_next = '0;
                end
                if (st.dir != DIR_NONE && move_due)
                begin
                    if (st.cur_pos > st.tgt_pos && st.dir == DIR_OPENING)
                    begin
                        st_next.cur_pos = pos_dec;
                        flags.swrite = 1'b1;
                        if (pos_dec <= st.tgt_pos)
                        begin
                            st_next.dir    = DIR_NONE;
                            st_next.status = ST_OPEN;
                            flags.save     = 1'b1;
                        end
                    end
                    else if (st.cur_pos < st.tgt_pos && st.dir == DIR_CLOSING)
                    begin
                        st_next.cur_pos = pos_inc;
                        flags.swrite = 1'b1;
                        if (pos_inc >= st.tgt_pos)
                        begin
                            st_next.dir    = DIR_NONE;
                            st_next.status = ST_CLOSED;
                            flags.save     = 1'b1;
                            if (st.light)
                            begin
                                st_next.tgt_level = st.chosen_level;
                            end
                        end
                    end
                    else
                    begin
                        // already at or past target: just stop the motor
                        st_next.dir = DIR_NONE;
                    end
                    move_next = '0;
                end
            end
            CMD_STARTUP:
            begin
                flags.swrite = 1'b1;
                flags.pwrite = 1'b1;
                if (cfg.start_open)
                begin
                    st_next.cur_pos = cfg.open_pos;
                    st_next.status  = ST_OPEN;
                end
                else
                begin
                    st_next.cur_pos = cfg.closed_pos;
                end
                if (cfg.panel_on_at_start)
                begin
                    st_next.cur_level = FULL_LEVEL;
                    st_next.tgt_level = FULL_LEVEL;
                    st_next.light     = 1'b1;
                end
                else
                begin
                    st_next.cur_level = '0;
                end
            end
            CMD_SHUTTER:
            begin
                if (val == VAL_W'(1) && st.status != ST_OPEN)
                begin
                    st_next.dir       = DIR_OPENING;
                    st_next.status    = ST_MOVING;
                    st_next.tgt_pos   = cfg.open_pos;
                    st_next.tgt_level = '0;
                end
                else if (val == '0 && st.status != ST_CLOSED)
                begin
                    st_next.dir     = DIR_CLOSING;
                    st_next.status  = ST_MOVING;
                    st_next.tgt_pos = cfg.closed_pos;
                end
            end
            CMD_HALT:
            begin
                if (st.dir != DIR_NONE)
                begin
                    st_next.dir     = DIR_NONE;
                    st_next.status  = ST_HALTED;
                    st_next.tgt_pos = st.cur_pos;
                end
            end
            CMD_LIGHT:
            begin
                st_next.light = (val != '0);
                if (val != '0)
                begin
                    if (st.status == ST_CLOSED)
                    begin
                        st_next.tgt_level = st.chosen_level;
                    end
                end
                else
                begin
                    st_next.tgt_level = '0;
                end
            end
            CMD_BRIGHT:
            begin
                st_next.chosen_level = val;
                if (st.light && st.status == ST_CLOSED)
                begin
                    st_next.tgt_level = val;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

// File: src/cover_servo_and_panel_fader_core.sv
// A result is registered: each item passes through the input register and then the result register.
// One item per cycle while out_stall is low; the state update is a single compare/increment step
// between the input register and the result register.
// Reset (rst_n, async, active low): empty pipeline, cover closed, motor stopped, light off,
// levels and positions 0, chosen level 255, tick counters saturated, config at defaults.
module cover_servo_and_panel_fader_core
    import cspf_pkg::*;
#(
    parameter int STEP_SIZE   = STEP_SIZE_DEF,
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [VAL_W-1:0]      value,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [POS_W-1:0]      servo_position,
    output logic                  servo_write,
    output logic [LEVEL_W-1:0]    panel_level,
    output logic                  panel_write,
    output logic [1:0]            cover_status,
    output logic [1:0]            motor_direction,
    output logic                  light_on,
    output logic                  save_request,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                   cfg_reg;
    state_t                 state_reg;
    state_t                 state_next;
    logic [DELAY_WIDTH-1:0] fade_ticks_reg;
    logic [DELAY_WIDTH-1:0] fade_ticks_next;
    logic [DELAY_WIDTH-1:0] move_ticks_reg;
    logic [DELAY_WIDTH-1:0] move_ticks_next;
    flags_t                 flags_next;

    logic                   in_valid_reg;
    logic [CMD_W-1:0]       in_cmd_reg;
    logic [VAL_W-1:0]       in_val_reg;
    logic                   out_valid_reg;
    state_t                 out_state_reg;
    flags_t                 out_flags_reg;

    logic                   out_ready;
    logic                   take;
    logic                   in_xfer;

    assign out_ready = !out_valid_reg || !out_stall;
    assign take      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    cspf_step #(
        .STEP_SIZE   (STEP_SIZE),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_step (
        .st         (state_reg),
        .cfg        (cfg_reg),
        .cmd        (in_cmd_reg),
        .val        (in_val_reg),
        .fade_ticks (fade_ticks_reg),
        .move_ticks (move_ticks_reg),
        .st_next    (state_next),
        .fade_next  (fade_ticks_next),
        .move_next  (move_ticks_next),
        .flags      (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_pos          <= OPEN_POS_RST;
            cfg_reg.closed_pos        <= CLOSED_POS_RST;
            cfg_reg.servo_delay       <= SERVO_DELAY_RST;
            cfg_reg.fade_delay        <= FADE_DELAY_RST;
            cfg_reg.start_open        <= 1'b0;
            cfg_reg.panel_on_at_start <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OPEN_POS:       cfg_reg.open_pos          <= cfg_data[POS_W-1:0];
                CFG_CLOSED_POS:     cfg_reg.closed_pos        <= cfg_data[POS_W-1:0];
                CFG_SERVO_DELAY:    cfg_reg.servo_delay       <= cfg_data[CFG_DELAY_W-1:0];
                CFG_FADE_DELAY:     cfg_reg.fade_delay        <= cfg_data[CFG_DELAY_W-1:0];
                CFG_START_OPEN:     cfg_reg.start_open        <= cfg_data[0];
                CFG_PANEL_AT_START: cfg_reg.panel_on_at_start <= cfg_data[0];
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cur_pos      <= '0;
            state_reg.tgt_pos      <= '0;
            state_reg.status       <= ST_CLOSED;
            state_reg.dir          <= DIR_NONE;
            state_reg.light        <= 1'b0;
            state_reg.chosen_level <= FULL_LEVEL;
            state_reg.tgt_level    <= '0;
            state_reg.cur_level    <= '0;
            fade_ticks_reg         <= '1;
            move_ticks_reg         <= '1;
        end
        else if (take)
        begin
            state_reg      <= state_next;
            fade_ticks_reg <= fade_ticks_next;
            move_ticks_reg <= move_ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_cmd_reg <= command;
            in_val_reg <= value;
        end
        if (take)
        begin
            out_state_reg <= state_next;
            out_flags_reg <= flags_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign servo_position  = out_state_reg.cur_pos;
    assign servo_write     = out_flags_reg.swrite;
    assign panel_level     = out_state_reg.cur_level;
    assign panel_write     = out_flags_reg.pwrite;
    assign cover_status    = out_state_reg.status;
    assign motor_direction = out_state_reg.dir;
    assign light_on        = out_state_reg.light;
    assign save_request    = out_flags_reg.save;

`ifndef SYNTH
    // a save pulse only comes with the motor stopped at an end position
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && save_request) |->
        (motor_direction == DIR_NONE &&
         (cover_status == ST_OPEN || cover_status == ST_CLOSED)))
    else $error("save request without finished move");

    // input stage only back-pressures while it holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
    else $error("stall with empty input register");

    // state moves only when an item passes into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(state_reg) && $stable(fade_ticks_reg) && $stable(move_ticks_reg)))
    else $error("state changed without a transfer");

    // a result is presented in the cycle after its item leaves the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
    else $error("item lost between stages");
`endif

endmodule
